// ===== design/nnms_pkg.sv =====
package nnms_pkg;

    // Fixed field widths
    localparam int COORD_W = 8;                  // col, row, src_col, src_row
    localparam int VAL_W   = 8;                  // cell_value, read_value
    localparam int COORD_N = 1 << COORD_W;       // distinct coordinate codes
    localparam int DIM_W   = 9;                  // extent registers
    localparam int TDATA_W = 3 * COORD_W;        // 24 bits, already whole bytes

    // Rounding divider: numerator 2*t*s + d, divisor 2*d
    localparam int NUM_W   = 2 * COORD_W + 2;    // 2*255*511 + 511 < 2^18
    localparam int DEN_W   = DIM_W + 1;
    localparam int STEPS   = NUM_W / 2;          // two quotient bits per cycle
    localparam int CNT_W   = $clog2(STEPS);

    // Configuration register indexes
    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_SRC_W = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_SRC_H = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_DST_W = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_DST_H = 2'd3;
    localparam logic [DIM_W-1:0]     DIM_RESET = 9'd256;

    // Controller to datapath commands
    typedef struct packed {
        logic load;      // set up numerator and divisor for the selected axis
        logic phase;     // 0: column axis, 1: row axis
        logic step;      // advance the divider by two quotient bits
        logic commit;    // clamp the quotient and hold it as the mapped coordinate
        logic mem_rd;    // read the source store at the mapped cell
        logic out_load;  // move the read result into the output register
    } t_nnms_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;  // output register empty or being drained this cycle
    } t_nnms_sts;

endpackage

// ===== design/nnms_ctrl.sv =====
module nnms_ctrl
    import nnms_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_s_tvalid,
    input  logic      i_req_read,
    output logic      o_s_tready,
    input  t_nnms_sts i_sts,
    output t_nnms_cmd o_cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LOAD = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_FIX  = 3'd3;
    localparam logic [2:0] ST_READ = 3'd4;
    localparam logic [2:0] ST_EMIT = 3'd5;

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_phase, n_phase;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_phase    = r_phase;
        o_cmd      = '0;
        o_s_tready = (r_state == ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid && i_req_read) begin
                    n_phase = 1'b0;
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                o_cmd.load  = 1'b1;
                o_cmd.phase = r_phase;
                n_cnt       = '0;
                n_state     = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.step = 1'b1;
                n_cnt      = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(STEPS - 1)) begin
                    n_state = ST_FIX;
                end
            end
            ST_FIX: begin
                o_cmd.commit = 1'b1;
                o_cmd.phase  = r_phase;
                if (!r_phase) begin
                    n_phase = 1'b1;
                    n_state = ST_LOAD;
                end else begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                o_cmd.mem_rd = 1'b1;
                n_state      = ST_EMIT;
            end
            ST_EMIT: begin
                // hold until the output register can take the result
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_phase <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_phase <= n_phase;
        end
    end

endmodule

// ===== design/nnms_dpath.sv =====
module nnms_dpath
    import nnms_pkg::*;
#(
    parameter int MAX_DIM    = 256,
    parameter int VALUE_BITS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [REG_IDX_W-1:0] i_cfg_idx,
    input  logic [DIM_W-1:0]     i_cfg_data,
    input  logic                 i_accept,
    input  logic                 i_req_read,
    input  logic [COORD_W-1:0]   i_col,
    input  logic [COORD_W-1:0]   i_row,
    input  logic [VAL_W-1:0]     i_cell_value,
    input  t_nnms_cmd            i_cmd,
    output t_nnms_sts            o_sts,
    input  logic                 i_m_tready,
    output logic                 o_m_tvalid,
    output logic [VAL_W-1:0]     o_read_value,
    output logic [COORD_W-1:0]   o_src_col,
    output logic [COORD_W-1:0]   o_src_row
);

    localparam int CW     = $clog2(MAX_DIM);
    localparam int ADDR_W = 2 * CW;
    localparam int DEPTH  = 1 << ADDR_W;

    // coordinate code -> coordinate modulo MAX_DIM
    function automatic logic [COORD_N*CW-1:0] build_mod_tab();
        logic [COORD_N*CW-1:0] tab;
        tab = '0;
        for (int i = 0; i < COORD_N; i++) begin
            tab[i*CW +: CW] = CW'(i % MAX_DIM);
        end
        return tab;
    endfunction

    localparam logic [COORD_N*CW-1:0] MOD_TAB = build_mod_tab();

    // zero reads as one, oversize reads as MAX_DIM
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
        if (v == '0) begin
            return DIM_W'(1);
        end else if (32'(v) > MAX_DIM) begin
            return DIM_W'(MAX_DIM);
        end else begin
            return v;
        end
    endfunction

    logic [DIM_W-1:0]             r_src_w, r_src_h, r_dst_w, r_dst_h;
    logic [COORD_W-1:0]           r_col_in, r_row_in;
    logic [NUM_W-1:0]             r_num, n_num;
    logic [DEN_W-1:0]             r_rem, n_rem;
    logic [DEN_W-1:0]             r_den;
    logic [DIM_W-1:0]             r_lim;
    logic [DIM_W-1:0]             r_map_col, r_map_row;
    logic [VALUE_BITS-1:0]        r_mem [DEPTH];
    logic [VALUE_BITS-1:0]        r_rd_data;
    logic                         r_out_valid;
    logic [VAL_W-1:0]             r_out_value;
    logic [COORD_W-1:0]           r_out_col, r_out_row;

    logic [COORD_W-1:0]           w_t;
    logic [DIM_W-1:0]             w_s, w_d;
    logic [COORD_W+DIM_W-1:0]     w_prod;
    logic [DIM_W-1:0]             w_q;
    logic [ADDR_W-1:0]            w_wr_addr, w_rd_addr;

    // operand select for the axis being mapped
    always_comb begin
        w_t    = i_cmd.phase ? r_row_in : r_col_in;
        w_s    = i_cmd.phase ? eff_dim(r_src_h) : eff_dim(r_src_w);
        w_d    = i_cmd.phase ? eff_dim(r_dst_h) : eff_dim(r_dst_w);
        w_prod = (COORD_W+DIM_W)'(w_t) * (COORD_W+DIM_W)'(w_s);
    end

    // two restoring division steps
    always_comb begin
        logic [DEN_W:0] v_try;
        n_num = r_num;
        n_rem = r_rem;
        for (int k = 0; k < 2; k++) begin
            v_try = {n_rem, n_num[NUM_W-1]};
            n_num = {n_num[NUM_W-2:0], 1'b0};
            if (v_try >= {1'b0, r_den}) begin
                v_try    = v_try - {1'b0, r_den};
                n_num[0] = 1'b1;
            end
            n_rem = v_try[DEN_W-1:0];
        end
    end

    assign w_q = (r_num > NUM_W'(r_lim)) ? r_lim : r_num[DIM_W-1:0];

    assign w_wr_addr = {MOD_TAB[i_col*CW +: CW], MOD_TAB[i_row*CW +: CW]};
    assign w_rd_addr = {CW'(r_map_col), CW'(r_map_row)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= DIM_RESET;
            r_src_h <= DIM_RESET;
            r_dst_w <= DIM_RESET;
            r_dst_h <= DIM_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SRC_W: r_src_w <= i_cfg_data;
                REG_SRC_H: r_src_h <= i_cfg_data;
                REG_DST_W: r_dst_w <= i_cfg_data;
                REG_DST_H: r_dst_h <= i_cfg_data;
                default:   r_dst_h <= r_dst_h;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_col_in <= i_col;
            r_row_in <= i_row;
        end
        if (i_cmd.load) begin
            r_num <= NUM_W'({w_prod, 1'b0}) + NUM_W'(w_d);
            r_rem <= '0;
            r_den <= {w_d, 1'b0};
            r_lim <= w_s - 1'b1;
        end else if (i_cmd.step) begin
            r_num <= n_num;
            r_rem <= n_rem;
        end
        if (i_cmd.commit) begin
            if (i_cmd.phase) begin
                r_map_row <= w_q;
            end else begin
                r_map_col <= w_q;
            end
        end
    end

    // source store
    always_ff @(posedge i_clk) begin
        if (i_accept && !i_req_read) begin
            r_mem[w_wr_addr] <= VALUE_BITS'(i_cell_value);
        end
        if (i_cmd.mem_rd) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_value <= VAL_W'(r_rd_data);
            r_out_col   <= r_map_col[COORD_W-1:0];
            r_out_row   <= r_map_row[COORD_W-1:0];
        end
    end

    assign o_sts.out_free = !r_out_valid || i_m_tready;
    assign o_m_tvalid     = r_out_valid;
    assign o_read_value   = r_out_value;
    assign o_src_col      = r_out_col;
    assign o_src_row      = r_out_row;

endmodule

// ===== design/nearest_neighbor_matrix_scaler_core.sv =====
// A read runs column divide, row divide, store read and output load before its result shows.
// Throughput: one write per cycle while no read is in progress; no request is taken while a read runs.
//   The read time is set by the shared divider (two quotient bits a cycle) run once per axis.
// The input is taken again as soon as a result sits in the output register.
// Reset (synchronous, active low) clears the controller, the output valid and sets all
//   four extent registers to 256; the source store is not cleared.
module nearest_neighbor_matrix_scaler_core
    import nnms_pkg::*;
#(
    parameter int MAX_DIM    = 256,
    parameter int VALUE_BITS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [REG_IDX_W-1:0] i_cfg_idx,
    input  logic [DIM_W-1:0]     i_cfg_data,
    // request stream
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [TDATA_W-1:0]   i_s_tdata,   // col[7:0], row[15:8], cell_value[23:16]
    input  logic                 i_s_tuser,   // req_type: 0 write, 1 read
    // result stream
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [TDATA_W-1:0]   o_m_tdata    // read_value[7:0], src_col[15:8], src_row[23:16]
);

    t_nnms_cmd          w_cmd;
    t_nnms_sts          w_sts;
    logic               w_accept;
    logic [VAL_W-1:0]   w_read_value;
    logic [COORD_W-1:0] w_src_col, w_src_row;

    // one transaction taken per valid/ready edge
    assign w_accept = i_s_tvalid && o_s_tready;

    // sequencer: divide column, divide row, read store, emit
    nnms_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_req_read (i_s_tuser),
        .o_s_tready (o_s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // extent registers, divider, source store and output register
    nnms_dpath #(
        .MAX_DIM    (MAX_DIM),
        .VALUE_BITS (VALUE_BITS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_accept     (w_accept),
        .i_req_read   (i_s_tuser),
        .i_col        (i_s_tdata[COORD_W-1:0]),
        .i_row        (i_s_tdata[2*COORD_W-1:COORD_W]),
        .i_cell_value (i_s_tdata[3*COORD_W-1:2*COORD_W]),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_m_tready   (i_m_tready),
        .o_m_tvalid   (o_m_tvalid),
        .o_read_value (w_read_value),
        .o_src_col    (w_src_col),
        .o_src_row    (w_src_row)
    );

    // pack result fields, lowest field first
    assign o_m_tdata = {w_src_row, w_src_col, w_read_value};

endmodule

// ===== design/nnms_checker.sv =====
module nnms_checker
    import nnms_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_s_tvalid,
    input logic               o_s_tready,
    input logic               i_s_tuser,
    input logic               o_m_tvalid,
    input logic               i_m_tready,
    input logic [TDATA_W-1:0] o_m_tdata
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("result dropped or changed while stalled");

    // a read keeps the input closed while it is mapped
    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_s_tuser) |=> !o_s_tready)
        else $error("input open right after a read transaction");

    // a write never produces a result
    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && !i_s_tuser && !o_m_tvalid) |=> !o_m_tvalid)
        else $error("result after a write transaction");

    // a result only appears at the end of a read in progress
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(!o_s_tready))
        else $error("result appeared while idle");

endmodule

bind nearest_neighbor_matrix_scaler_core nnms_checker u_nnms_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

// ===== verif/nearest_neighbor_matrix_scaler_core_test.sv =====
`timescale 1ns / 100ps

module nearest_neighbor_matrix_scaler_core_test;
    import nnms_pkg::*;

    // Scale of the run
    localparam int RANDOM_PER_PHASE = 105;   // random items per configuration phase
    localparam int SETTLE_CYCLES    = 30;    // settle time after the queues drain
    localparam int LONG_HOLD        = 200;   // one long receiver stall
    localparam int WATCHDOG_LIMIT   = 2000;  // cycles without any transaction

    typedef enum logic {
        REQ_WRITE = 1'b0,
        REQ_READ  = 1'b1
    } t_req_kind;

    // One request: kind travels on tuser, the rest packs into tdata
    typedef struct packed {
        t_req_kind            kind;
        logic [VAL_W-1:0]     cell_value;
        logic [COORD_W-1:0]   row;
        logic [COORD_W-1:0]   col;
    } t_scale_req;

    // One result, laid out exactly as o_m_tdata
    typedef struct packed {
        logic [COORD_W-1:0]   src_row;
        logic [COORD_W-1:0]   src_col;
        logic [VAL_W-1:0]     read_value;
    } t_scaled_pixel;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_cfg_we   = 1'b0;
    logic [REG_IDX_W-1:0] i_cfg_idx  = '0;
    logic [DIM_W-1:0]     i_cfg_data = '0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [TDATA_W-1:0]   i_s_tdata  = '0;   // col[7:0], row[15:8], cell_value[23:16]
    logic                 i_s_tuser  = 1'b0; // req_type: 0 write, 1 read
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    logic [TDATA_W-1:0]   o_m_tdata;         // read_value[7:0], src_col[15:8], src_row[23:16]

    nearest_neighbor_matrix_scaler_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow of the extent registers, indexed like the configuration port
    logic [DIM_W-1:0] extent_reg [4] = '{DIM_RESET, DIM_RESET, DIM_RESET, DIM_RESET};

    // Shadow of the source store, indexed by {column, row}
    logic [VAL_W-1:0] cell_store   [COORD_N*COORD_N];
    // Cells the stimulus has already written; reads only ever land on these
    bit               cell_written [COORD_N*COORD_N];

    t_scale_req    pending_requests [$];   // filled by the stimulus, drained by the driver
    t_scaled_pixel expected_pixels  [$];   // one entry per accepted read, oldest first

    t_scale_req    next_req;
    t_scale_req    offered_req;
    t_scaled_pixel got_px;
    t_scaled_pixel want_px;

    int  error_count     = 0;
    int  tx_gap          = 0;
    int  rx_gap          = 0;
    int  long_hold_cnt   = 0;
    int  quiet_cycles    = 0;
    bit  steady_flow     = 1'b0;  // no idling on either side in the final phase
    bit  long_hold_armed = 1'b0;

    task automatic flag_error(input string msg);
        error_count++;
        $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // Nearest source index: floor((2*t*s + d) / (2*d)), clamped to s-1.
    // An extent of zero counts as one, anything past the store size as the store size.
    function automatic logic [COORD_W-1:0] nearest_source(input logic [COORD_W-1:0] t,
                                                          input logic [DIM_W-1:0]   s_reg,
                                                          input logic [DIM_W-1:0]   d_reg);
        int unsigned s;
        int unsigned d;
        int unsigned q;
        s = (s_reg == 0) ? 1 : (s_reg > COORD_N) ? COORD_N : s_reg;
        d = (d_reg == 0) ? 1 : (d_reg > COORD_N) ? COORD_N : d_reg;
        q = (2 * t * s + d) / (2 * d);
        if (q > s - 1)
            q = s - 1;
        return q[COORD_W-1:0];
    endfunction

    // Scaler predictor: update the store on a write, queue the scaled pixel on a read
    function automatic void predict_scaled_pixel(input t_scale_req rq);
        logic [COORD_W-1:0] sc;
        logic [COORD_W-1:0] sr;
        if (rq.kind == REQ_WRITE) begin
            cell_store[{rq.col, rq.row}] = rq.cell_value;
        end else begin
            sc = nearest_source(rq.col, extent_reg[REG_SRC_W], extent_reg[REG_DST_W]);
            sr = nearest_source(rq.row, extent_reg[REG_SRC_H], extent_reg[REG_DST_H]);
            expected_pixels.push_back('{src_row: sr, src_col: sc,
                                        read_value: cell_store[{sc, sr}]});
        end
    endfunction

    function automatic void queue_write(input logic [COORD_W-1:0] c,
                                        input logic [COORD_W-1:0] r,
                                        input logic [VAL_W-1:0]   v);
        cell_written[{c, r}] = 1'b1;
        pending_requests.push_back('{kind: REQ_WRITE, cell_value: v, row: r, col: c});
    endfunction

    // Queue a read; write the mapped source cell first if nothing has landed there yet
    function automatic void queue_read(input logic [COORD_W-1:0] c,
                                       input logic [COORD_W-1:0] r);
        logic [COORD_W-1:0] sc;
        logic [COORD_W-1:0] sr;
        sc = nearest_source(c, extent_reg[REG_SRC_W], extent_reg[REG_DST_W]);
        sr = nearest_source(r, extent_reg[REG_SRC_H], extent_reg[REG_DST_H]);
        if (!cell_written[{sc, sr}])
            queue_write(sc, sr, VAL_W'($urandom));
        pending_requests.push_back('{kind: REQ_READ, cell_value: VAL_W'($urandom),
                                     row: r, col: c});
    endfunction

    function automatic void fill_random(input int count);
        repeat (count) begin
            if ($urandom_range(0, 1) == 0)
                queue_write(COORD_W'($urandom_range(0, 255)), COORD_W'($urandom_range(0, 255)),
                            VAL_W'($urandom_range(0, 255)));
            else
                queue_read(COORD_W'($urandom_range(0, 255)), COORD_W'($urandom_range(0, 255)));
        end
    endfunction

    // Write one extent register; only called while the block is idle
    task automatic write_extent(input logic [REG_IDX_W-1:0] idx, input logic [DIM_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        extent_reg[idx] = value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_extents(input logic [DIM_W-1:0] sw, input logic [DIM_W-1:0] sh,
                               input logic [DIM_W-1:0] dw, input logic [DIM_W-1:0] dh);
        write_extent(REG_SRC_W, sw);
        write_extent(REG_SRC_H, sh);
        write_extent(REG_DST_W, dw);
        write_extent(REG_DST_H, dh);
        @(negedge i_clk);
    endtask

    // Hold until every request is accepted and every result is back, then let the
    // last write settle. Sample at the falling edge so the driver's updates are final.
    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (pending_requests.size() != 0 || i_s_tvalid || expected_pixels.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Request driver: predict on every accepted transaction, then offer the next one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            tx_gap     <= 0;
        end else begin
            if (i_s_tvalid && o_s_tready)
                predict_scaled_pixel(offered_req);
            // Advance only when nothing is offered or the offer was just taken
            if (!i_s_tvalid || o_s_tready) begin
                if (tx_gap != 0) begin
                    tx_gap     <= tx_gap - 1;
                    i_s_tvalid <= 1'b0;
                end else if (pending_requests.size() == 0) begin
                    i_s_tvalid <= 1'b0;
                end else if (!steady_flow && $urandom_range(0, 5) == 0) begin
                    // idle burst, its extra length drawn into tx_gap
                    tx_gap     <= $urandom_range(0, 2);
                    i_s_tvalid <= 1'b0;
                end else begin
                    next_req     = pending_requests.pop_front();
                    offered_req <= next_req;
                    i_s_tdata   <= {next_req.cell_value, next_req.row, next_req.col};
                    i_s_tuser   <= next_req.kind;
                    i_s_tvalid  <= 1'b1;
                end
            end
        end
    end

    // Result monitor: check each accepted transaction, then pick the next tready
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready    <= 1'b0;
            rx_gap        <= 0;
            long_hold_cnt <= 0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                got_px = o_m_tdata;
                if (expected_pixels.size() == 0) begin
                    flag_error($sformatf("result transaction %h with no read outstanding",
                                         got_px));
                end else begin
                    want_px = expected_pixels.pop_front();
                    if (got_px.read_value !== want_px.read_value)
                        flag_error($sformatf("read_value got %h want %h",
                                             got_px.read_value, want_px.read_value));
                    if (got_px.src_col !== want_px.src_col)
                        flag_error($sformatf("src_col got %0d want %0d",
                                             got_px.src_col, want_px.src_col));
                    if (got_px.src_row !== want_px.src_row)
                        flag_error($sformatf("src_row got %0d want %0d",
                                             got_px.src_row, want_px.src_row));
                end
            end
            // Hold off once for a long stretch so the block backs up into its input
            if (long_hold_armed && long_hold_cnt < LONG_HOLD) begin
                long_hold_cnt <= long_hold_cnt + 1;
                i_m_tready    <= 1'b0;
            end else if (rx_gap != 0) begin
                rx_gap     <= rx_gap - 1;
                i_m_tready <= 1'b0;
            end else if (!steady_flow && $urandom_range(0, 4) == 0) begin
                rx_gap     <= $urandom_range(0, 2);
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: any transaction, config write or reset restarts the count
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset extents map every target cell onto itself: hit the corners and the
        // value extremes, overwrite a cell, and read with a random ignored value.
        queue_write(8'd0,   8'd0,   8'h00);
        queue_write(8'd255, 8'd255, 8'hFF);
        queue_write(8'd0,   8'd255, 8'hA5);
        queue_write(8'd255, 8'd0,   8'h5A);
        queue_write(8'd128, 8'd127, 8'h81);
        queue_read(8'd0,   8'd0);
        queue_read(8'd255, 8'd255);
        queue_read(8'd0,   8'd255);
        queue_read(8'd255, 8'd0);
        queue_read(8'd128, 8'd127);
        queue_write(8'd0,  8'd0,   8'hFF);
        queue_read(8'd0,   8'd0);
        wait_drained();

        // Downscale from 3x5 to 2x2 target: exact halves round up (col 1 -> 2,
        // row 1 -> 3), and targets past the extent clamp to the last source cell.
        set_extents(9'd3, 9'd5, 9'd2, 9'd2);
        queue_read(8'd0,   8'd0);
        queue_read(8'd1,   8'd1);
        queue_read(8'd2,   8'd2);
        queue_read(8'd255, 8'd255);
        queue_read(8'd128, 8'd3);
        fill_random(RANDOM_PER_PHASE);
        wait_drained();

        // Zero and oversized extents, with the long receiver stall in this phase
        set_extents(9'd0, 9'd511, 9'd511, 9'd0);
        long_hold_armed = 1'b1;
        fill_random(RANDOM_PER_PHASE);
        wait_drained();

        set_extents(9'd257, 9'd1, 9'd1, 9'd256);
        fill_random(RANDOM_PER_PHASE);
        wait_drained();

        repeat (2) begin
            set_extents(DIM_W'($urandom_range(0, 511)), DIM_W'($urandom_range(0, 511)),
                        DIM_W'($urandom_range(0, 511)), DIM_W'($urandom_range(0, 511)));
            fill_random(RANDOM_PER_PHASE);
            wait_drained();
        end

        // Last phase runs with both sides streaming at full rate
        set_extents(DIM_W'($urandom_range(1, 256)), DIM_W'($urandom_range(1, 256)),
                    DIM_W'($urandom_range(1, 256)), DIM_W'($urandom_range(1, 256)));
        steady_flow = 1'b1;
        fill_random(RANDOM_PER_PHASE);
        wait_drained();

        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
